// File: hdl/rlsb_pkg.sv
// Shared types, constants and widths of the record-and-loop sample buffer.
package rlsb_pkg;

	// Storage geometry.
	localparam int STORE_DEPTH = 524288;
	localparam int SAMPLE_BITS = 24;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int LEN_W       = $clog2(STORE_DEPTH + 1);

	// Configuration register.
	localparam int LIMIT_W = 20;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(480000);
	localparam int CFG_ADDR_W = 3;
	localparam logic [CFG_ADDR_W-3:0] REG_RECORD_LIMIT = '0;

	// Compare width that holds the limit, the length and one more.
	localparam int CMP_W = ((LIMIT_W > LEN_W) ? LIMIT_W : LEN_W) + 1;

	// Mode codes.
	localparam logic [1:0] MODE_LIVE   = 2'd0;
	localparam logic [1:0] MODE_RECORD = 2'd1;
	localparam logic [1:0] MODE_LOOP   = 2'd2;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] in_sample;
		logic [1:0]                    requested_mode;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] out_sample;
		logic [LEN_W-1:0]              recorded_count;
		logic [1:0]                    active_mode;
		logic                          stop_request;
	} out_item_t;

	// Per-request decision from the control unit.
	typedef struct packed {
		logic              we;
		logic              re;
		logic [ADDR_W-1:0] waddr;
		logic [ADDR_W-1:0] raddr;
		logic [1:0]        mode;
		logic [LEN_W-1:0]  count;
		logic              stop;
	} step_t;

endpackage

// File: hdl/rlsb_if.sv
// Stream channel interfaces for input requests and results.
interface rlsb_in_if;
	import rlsb_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rlsb_out_if;
	import rlsb_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: hdl/rlsb_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
module rlsb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: hdl/rlsb_ctrl.sv
// Mode, length and play position control; decides store accesses per request.
module rlsb_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic [1:0]                  req_mode,
	input  logic [rlsb_pkg::LIMIT_W-1:0] limit,
	output rlsb_pkg::step_t             res
);
	import rlsb_pkg::*;

	logic [LEN_W-1:0]  len_q;
	logic [ADDR_W-1:0] pos_q;
	logic [1:0]        last_mode_q;
	logic              latch_q;

	logic [1:0]       mode_req, mode_a, mode_b;
	logic             changed, rec, hit, play;
	logic [LEN_W-1:0] len_a, len_n;
	logic [ADDR_W-1:0] pos_a, pos_c, pos_n;
	logic [CMP_W-1:0] lim_c, lim_eff, len_inc, pos_inc;

	always_comb begin
		if (req_mode == MODE_RECORD) begin
			mode_req = MODE_RECORD;
		end else if (req_mode == MODE_LOOP) begin
			mode_req = MODE_LOOP;
		end else begin
			mode_req = MODE_LIVE;
		end

		// hold live while a filled recording still sees a record request
		mode_a  = (latch_q && mode_req == MODE_RECORD) ? MODE_LIVE : mode_req;
		changed = (mode_a != last_mode_q);
		len_a   = (changed && mode_a == MODE_RECORD) ? '0 : len_q;
		pos_a   = (changed && mode_a == MODE_LOOP) ? '0 : pos_q;
		mode_b  = (mode_a == MODE_LOOP && len_a == '0) ? MODE_LIVE : mode_a;

		// effective limit: zero means one, saturate at store depth
		lim_c   = (limit == '0) ? CMP_W'(1) : CMP_W'(limit);
		lim_eff = (lim_c > CMP_W'(STORE_DEPTH)) ? CMP_W'(STORE_DEPTH) : lim_c;

		rec     = (mode_b == MODE_RECORD);
		len_inc = CMP_W'(len_a) + CMP_W'(1);
		hit     = rec && (len_inc >= lim_eff);
		if (rec) begin
			len_n = (len_inc > CMP_W'(STORE_DEPTH)) ? LEN_W'(STORE_DEPTH) : LEN_W'(len_inc);
		end else begin
			len_n = len_a;
		end

		play    = (mode_b == MODE_LOOP);
		pos_c   = (CMP_W'(pos_a) >= CMP_W'(STORE_DEPTH) || CMP_W'(pos_a) >= CMP_W'(len_a))
			? '0 : pos_a;
		pos_inc = CMP_W'(pos_c) + CMP_W'(1);
		if (play) begin
			pos_n = (pos_inc >= CMP_W'(len_a)) ? '0 : ADDR_W'(pos_inc);
		end else begin
			pos_n = pos_a;
		end

		res.we    = rec && (CMP_W'(len_a) < CMP_W'(STORE_DEPTH));
		res.waddr = ADDR_W'(len_a);
		res.re    = play;
		res.raddr = pos_c;
		res.mode  = hit ? MODE_LIVE : mode_b;
		res.count = len_n;
		res.stop  = hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			pos_q       <= '0;
			last_mode_q <= MODE_LIVE;
			latch_q     <= 1'b0;
		end else if (step) begin
			len_q       <= len_n;
			pos_q       <= pos_n;
			last_mode_q <= hit ? MODE_LIVE : mode_a;
			latch_q     <= hit || (latch_q && mode_req == MODE_RECORD);
		end
	end

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(len_q) <= CMP_W'(STORE_DEPTH))
		else $error("stored length above store depth");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(last_mode_q == MODE_LOOP && len_q != '0) |-> (LEN_W'(pos_q) < len_q))
		else $error("play position outside recording while looping");

	a_latch_live: assert property (@(posedge clk) disable iff (!arst_n)
		latch_q |-> (last_mode_q == MODE_LIVE))
		else $error("full-stop latch set outside live mode");
endmodule

// File: hdl/record_and_loop_sample_buffer_core.sv
// Top level of the record-and-loop sample buffer: APB register, store and result pipeline.
// A request moves from the read stage into the result register, where its result is offered;
// a full result register that is not being drained holds it in the read stage.
// Throughput: one request per cycle while the result side is not stalled; the store's registered
// read sets the two-stage pipe (read stage, then result register).
// Reset: asynchronous, active low; clears mode, length, position, latch and pipeline valids
// and sets record_limit to 480000. Store contents are undefined until recorded; no clearing pass.
module record_and_loop_sample_buffer_core (
	input  logic                            clk,
	input  logic                            arst_n,
	rlsb_in_if.sink                         in_ch,
	rlsb_out_if.source                      out_ch,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rlsb_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);
	import rlsb_pkg::*;

	// Configuration register. Decode on the word index so byte offsets alias.
	logic [LIMIT_W-1:0] limit_q;
	logic               sel_limit;

	assign pready    = 1'b1;
	assign sel_limit = (paddr[CFG_ADDR_W-1:2] == REG_RECORD_LIMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && pready && sel_limit) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	always_comb begin
		prdata = sel_limit ? 32'(limit_q) : 32'd0;
	end

	// Handshakes. The read stage advances into the result register when that
	// register is empty or being drained; a new request enters when the read
	// stage is empty or advancing.
	logic valid_s1;
	logic out_valid_q;
	logic s1_adv;
	logic accept;

	assign s1_adv      = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || s1_adv;
	assign accept      = in_ch.valid && in_ch.ready;

	// Control: decides mode, new length, and which store entry to write or read.
	step_t step;

	rlsb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (accept),
		.req_mode (in_ch.data.requested_mode),
		.limit    (limit_q),
		.res      (step)
	);

	// Sample store. A request either writes or reads, never both, and a read
	// issued after a write already sees it, so no forwarding is needed.
	logic                   ram_we, ram_re;
	logic [SAMPLE_BITS-1:0] ram_rdata;

	assign ram_we = accept && step.we;
	assign ram_re = accept && step.re;

	rlsb_ram #(
		.WIDTH (SAMPLE_BITS),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (step.waddr),
		.wdata (in_ch.data.in_sample),
		.re    (ram_re),
		.raddr (step.raddr),
		.rdata (ram_rdata)
	);

	// Read stage: hold the decision while the store read completes.
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic                   play_s1;
	logic [LEN_W-1:0]       count_s1;
	logic [1:0]             mode_s1;
	logic                   stop_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= in_ch.data.in_sample;
			play_s1   <= step.re;
			count_s1  <= step.count;
			mode_s1   <= step.mode;
			stop_s1   <= step.stop;
		end
	end

	// Result register: pick playback or passthrough sample.
	out_item_t out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q.out_sample     <= play_s1 ? ram_rdata : sample_s1;
			out_q.recorded_count <= count_s1;
			out_q.active_mode    <= mode_s1;
			out_q.stop_request   <= stop_s1;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("store written and read by one request");

	a_rdata_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |=> $stable(ram_rdata))
		else $error("store read data changed under a stalled read stage");

	a_stop_is_live: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && stop_s1) |-> (mode_s1 == MODE_LIVE && !play_s1))
		else $error("stop request raised outside live mode");
endmodule

// File: tb/rlsb_checker.sv
// Checker for the record-and-loop sample buffer: watches both channels and the register port.
`timescale 1ns / 1ps

module rlsb_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	rlsb_in_if                              in_mon,
	rlsb_out_if                             out_mon,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic                            pready,
	input  logic [rlsb_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	output int                              mismatch_count,
	output int                              due_count
);
	import rlsb_pkg::*;

	// Own copy of the looper state.
	logic signed [SAMPLE_BITS-1:0] take_store [STORE_DEPTH];
	int                            take_len;
	int                            play_pos;
	logic [1:0]                    prev_mode;
	logic                          stop_latched;
	logic [LIMIT_W-1:0]            limit_reg;

	out_item_t                     due_outputs [$];

	task automatic report_mismatch(string field, int got, int want);
		$display("%0t ns: %s got %0d want %0d", $time, field, got, want);
		mismatch_count++;
	endtask

	// Apply one request to the state and return the result it produces.
	function automatic out_item_t advance_looper(in_item_t req);
		out_item_t  r;
		logic [1:0] mode;
		int         lim;
		mode = (req.requested_mode == MODE_RECORD) ? MODE_RECORD :
		       (req.requested_mode == MODE_LOOP)   ? MODE_LOOP   : MODE_LIVE;
		r.out_sample   = req.in_sample;
		r.stop_request = 1'b0;
		// A filled take holds the block live while record is still requested.
		if (stop_latched) begin
			if (mode == MODE_RECORD) mode = MODE_LIVE;
			else stop_latched = 1'b0;
		end
		if (mode != prev_mode) begin
			if (mode == MODE_RECORD) take_len = 0;
			if (mode == MODE_LOOP) play_pos = 0;
			prev_mode = mode;
		end
		if (mode == MODE_LOOP && take_len == 0) mode = MODE_LIVE;
		if (mode == MODE_RECORD) begin
			if (take_len < STORE_DEPTH) take_store[take_len] = req.in_sample;
			take_len++;
			lim = int'(limit_reg);
			if (lim == 0) lim = 1;
			if (lim > STORE_DEPTH) lim = STORE_DEPTH;
			if (take_len >= lim) begin
				if (take_len > STORE_DEPTH) take_len = STORE_DEPTH;
				mode           = MODE_LIVE;
				prev_mode      = MODE_LIVE;
				stop_latched   = 1'b1;
				r.stop_request = 1'b1;
			end
		end
		if (mode == MODE_LOOP) begin
			if (play_pos >= STORE_DEPTH || play_pos >= take_len) play_pos = 0;
			r.out_sample = take_store[play_pos];
			play_pos++;
			if (play_pos >= take_len) play_pos = 0;
		end
		r.recorded_count = LEN_W'(take_len);
		r.active_mode    = mode;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		out_item_t got;
		if (!arst_n) begin
			take_len       = 0;
			play_pos       = 0;
			prev_mode      = MODE_LIVE;
			stop_latched   = 1'b0;
			limit_reg      = LIMIT_RESET;
			mismatch_count = 0;
			due_outputs.delete();
			due_count      = 0;
		end else begin
			if (out_mon.valid && out_mon.ready) begin
				got = out_mon.data;
				if (due_outputs.size() == 0) begin
					report_mismatch("result with nothing pending, out_sample",
						int'(got.out_sample), 0);
				end else begin
					want = due_outputs.pop_front();
					if (got.out_sample !== want.out_sample)
						report_mismatch("out_sample", int'(got.out_sample),
							int'(want.out_sample));
					if (got.recorded_count !== want.recorded_count)
						report_mismatch("recorded_count", int'(got.recorded_count),
							int'(want.recorded_count));
					if (got.active_mode !== want.active_mode)
						report_mismatch("active_mode", int'(got.active_mode),
							int'(want.active_mode));
					if (got.stop_request !== want.stop_request)
						report_mismatch("stop_request", int'(got.stop_request),
							int'(want.stop_request));
				end
			end
			if (in_mon.valid && in_mon.ready) begin
				due_outputs.push_back(advance_looper(in_mon.data));
			end
			if (psel && penable && pwrite && pready &&
			    paddr[CFG_ADDR_W-1:2] == REG_RECORD_LIMIT) begin
				limit_reg = pwdata[LIMIT_W-1:0];
			end
			due_count = due_outputs.size();
		end
	end

endmodule

// File: tb/record_and_loop_sample_buffer_core_tb.sv
// Testbench top of the record-and-loop sample buffer: stimulus, register writes and verdict.
`timescale 1ns / 1ps

module record_and_loop_sample_buffer_core_tb;
	import rlsb_pkg::*;

	// Spare mode code; the block treats it as live.
	localparam logic [1:0] MODE_SPARE = 2'd3;
	// Byte address of the record limit register.
	localparam logic [CFG_ADDR_W-1:0] LIMIT_ADDR = {REG_RECORD_LIMIT, 2'b00};
	// Cycles without any handshake before the run is declared hung.
	localparam int STALL_LIMIT = 3000;
	localparam int PHASE_ITEMS = 200;

	localparam logic signed [SAMPLE_BITS-1:0] S_MAX  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] S_MIN  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [SAMPLE_BITS-1:0] S_ZERO = '0;
	localparam logic signed [SAMPLE_BITS-1:0] S_NEG1 = '1;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	int                 fail_total;
	int                 due_total;
	int                 quiet_cycles;
	// Set to switch off idling on both sides for a whole phase.
	bit                 calm;
	int                 limit_now;
	int                 limit_plan [8];

	rlsb_in_if  in_ch ();
	rlsb_out_if out_ch ();

	record_and_loop_sample_buffer_core DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	rlsb_checker CHK (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_mon         (in_ch),
		.out_mon        (out_ch),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.mismatch_count (fail_total),
		.due_count      (due_total)
	);

	always #5 clk = ~clk;

	// Stall the result side in about a third of the cycles, unless calm.
	always @(negedge clk) begin
		out_ch.ready <= calm || ($urandom_range(99) >= 34);
	end

	// Pick a sample, biased toward the extremes of the Q1.23 range.
	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(9))
			0:       return S_MAX;
			1:       return S_MIN;
			2:       return S_ZERO;
			3:       return S_NEG1;
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	// Offer one request and hold it until accepted; return at a falling edge.
	task automatic send_request(logic signed [SAMPLE_BITS-1:0] smp, logic [1:0] mode);
		in_item_t item;
		item.in_sample      = smp;
		item.requested_mode = mode;
		// Idle the sender for a random gap first.
		while (!calm && $urandom_range(99) < 34) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data  <= item;
		do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
		@(negedge clk);
	endtask

	// Drop valid and wait until every pending result has come out.
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (due_total != 0) @(negedge clk);
		// Let the two-stage pipe settle before touching the register.
		repeat (4) @(negedge clk);
	endtask

	// Setup cycle, then access cycle; the write lands when pready is seen.
	task automatic program_record_limit(int value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= LIMIT_ADDR;
		pwdata  <= 32'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		limit_now = value;
	endtask

	// Random phase: mostly record and loop runs with random content, some live runs and noise.
	task automatic run_phase(int quota);
		int         sent;
		int         n;
		int         kind;
		int         rec_span;
		logic [1:0] m;
		sent = 0;
		// Let record runs overshoot small limits so held-record gets exercised.
		rec_span = (limit_now >= 1 && limit_now < 40) ? limit_now + 3 :
		           (limit_now == 0) ? 4 : 40;
		while (sent < quota) begin
			kind = $urandom_range(99);
			if (kind < 10) begin
				// Noise: one request with a fully random mode.
				n = 1;
				send_request(pick_sample(), 2'($urandom));
			end else if (kind < 45) begin
				n = $urandom_range(rec_span, 1);
				repeat (n) send_request(pick_sample(), MODE_RECORD);
			end else if (kind < 80) begin
				n = $urandom_range(48, 1);
				repeat (n) send_request(pick_sample(), MODE_LOOP);
			end else begin
				n = $urandom_range(6, 1);
				repeat (n) begin
					m = $urandom_range(1) ? MODE_LIVE : MODE_SPARE;
					send_request(pick_sample(), m);
				end
			end
			sent += n;
		end
	endtask

	// Watchdog: end the run if nothing moves for too long.
	initial begin
		quiet_cycles = 0;
		do begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
			    (psel && penable && pready) || !arst_n)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end while (quiet_cycles < STALL_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		calm         = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		in_ch.valid  = 1'b0;
		in_ch.data   = '0;
		out_ch.ready = 1'b0;
		limit_now    = int'(LIMIT_RESET);
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, with the reset limit in force.
		send_request(S_MAX, MODE_LIVE);
		// Spare mode code passes through as live.
		send_request(S_MIN, MODE_SPARE);
		// Loop on an empty store: passes through, reported live.
		send_request(S_NEG1, MODE_LOOP);
		// Record the range extremes, then loop past the end to wrap.
		send_request(S_MAX, MODE_RECORD);
		send_request(S_MIN, MODE_RECORD);
		send_request(S_ZERO, MODE_RECORD);
		repeat (4) send_request(pick_sample(), MODE_LOOP);
		send_request(pick_sample(), MODE_LIVE);
		// Re-entering record restarts the take.
		send_request(24'sh123456, MODE_RECORD);
		send_request(-24'sh0ABCDE, MODE_RECORD);

		// Lower the limit under the length of a take still in progress.
		drain();
		program_record_limit(1);
		send_request(24'sh555555, MODE_RECORD);
		// Held record after the fill stays live.
		repeat (2) send_request(pick_sample(), MODE_RECORD);
		send_request(pick_sample(), MODE_LIVE);
		repeat (3) send_request(pick_sample(), MODE_LOOP);

		// A zero limit behaves as one.
		drain();
		program_record_limit(0);
		send_request(24'sh2AAAAA, MODE_RECORD);
		send_request(pick_sample(), MODE_RECORD);
		repeat (2) send_request(pick_sample(), MODE_LOOP);

		// Random phases across a spread of limits, extremes included.
		limit_plan = '{2, (1 << LIMIT_W) - 1, STORE_DEPTH, $urandom_range(64, 3), 1,
			$urandom_range(300, 65), 0, int'(LIMIT_RESET)};
		foreach (limit_plan[p]) begin
			drain();
			program_record_limit(limit_plan[p]);
			calm = (p == 3);
			if (p == 2) begin
				// Hold the sender until everything in flight has come back.
				run_phase(PHASE_ITEMS / 2);
				drain();
				run_phase(PHASE_ITEMS / 2);
			end else begin
				run_phase(PHASE_ITEMS);
			end
		end
		calm = 1'b0;
		drain();

		if (fail_total == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
